[rtl/tpb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold promote page buffer package
// Sizes, register indexes, sequencer states and the item, result and
// entry-row control types shared by the buffer modules.
// ----------------------------------------------------------------------------
package tpb_pkg;

  localparam int unsigned MAX_ENTRIES = 8;
  localparam int unsigned TAG_WIDTH   = 32;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned HELD_W      = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned THR_W       = 16;
  localparam int unsigned CAP_W       = 4;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned OCC_W       = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [THR_W-1:0]       THRESHOLD_RESET = THR_W'(3);
  localparam logic [CAP_W-1:0]       CAPACITY_RESET  = CAP_W'(5);
  localparam logic [COUNT_WIDTH-1:0] NEW_COUNT       = COUNT_WIDTH'(1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = CFG_IDX_W'(1);

  // Item actions
  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic                 action;
    logic [TAG_WIDTH-1:0] page_tag;
  } req_t;

  typedef struct packed {
    logic                   hit;
    logic                   promoted;
    logic                   evicted;
    logic [TAG_WIDTH-1:0]   evicted_tag;
    logic [COUNT_WIDTH-1:0] request_count;
    logic [OCC_W-1:0]       occupancy;
    logic [TOTAL_W-1:0]     total_requests;
  } result_t;

  // Write controls for the entry row
  typedef struct packed {
    logic                   shift_en;
    logic [IDX_W-1:0]       shift_top;
    logic                   head_wr;
    logic [TAG_WIDTH-1:0]   head_tag;
    logic [COUNT_WIDTH-1:0] head_count;
    logic                   upd_en;
    logic [IDX_W-1:0]       upd_idx;
    logic [COUNT_WIDTH-1:0] upd_count;
  } row_ctrl_t;

endpackage

[rtl/threshold_promote_page_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold promote page buffer
// Ordered buffer of page tags with request counts; hits past the threshold
// move to the head, misses insert at the head and evict the tail when full.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel: drive req_i and raise start; the item is taken at a rising
//   edge with start high and busy low. busy stays high while the item is
//   worked on. Action clear empties the buffer; action access looks up the tag.
//   Result channel: result_valid_o strobes for exactly one cycle with result_o.
//   The receiver cannot stall; take the result in that cycle.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   ready is always high. Write only while no item is in flight.
// Sequencing:
//   A clear gives its result the cycle after acceptance; busy never rises.
//   An access scans the held entries one per cycle through a single tag
//   comparator, then applies the shift or count update in the update state.
//   Busy stays high through the scan and the update, so the scan length sets
//   how long an item takes from start to start. The result strobe coincides
//   with busy falling.
// Reset:
//   Occupancy and the request total clear, threshold returns to 3 and capacity
//   to 5. Tag and count storage is not cleared; entries beyond occupancy are
//   never read.
// ----------------------------------------------------------------------------
module threshold_promote_page_buffer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  tpb_pkg::req_t                   req_i,
  output logic                            result_valid_o,
  output tpb_pkg::result_t                result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tpb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tpb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tpb_pkg::*;

  state_e                 state_q, state_d;
  logic [HELD_W-1:0]      idx_q, idx_d;
  logic [TAG_WIDTH-1:0]   tag_q, tag_d;
  logic                   hit_q, hit_d;
  logic [IDX_W-1:0]       hit_idx_q, hit_idx_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [TAG_WIDTH-1:0]   ev_tag_q, ev_tag_d;
  logic [HELD_W-1:0]      held_q, held_d;
  logic [TOTAL_W-1:0]     total_q, total_d;
  logic [THR_W-1:0]       thr_q;
  logic [CAP_W-1:0]       cap_q;
  result_t                result_q, result_d;
  logic                   result_valid_q, result_valid_d;

  row_ctrl_t              row_ctrl;
  logic [TAG_WIDTH-1:0]   rd_tag;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [HELD_W-1:0]      cap_eff;
  logic [HELD_W-1:0]      new_held;
  logic                   search_end;
  logic                   match;
  logic                   promote;
  logic                   evict;
  logic                   accept;

  // Entry storage
  tpb_entry_row u_row (
    .clk_i      (clk_i),
    .ctrl_i     (row_ctrl),
    .rd_idx_i   (idx_q[IDX_W-1:0]),
    .rd_tag_o   (rd_tag),
    .rd_count_o (rd_count)
  );

  // Configuration registers; always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RESET;
      cap_q <= CAPACITY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_THRESHOLD: thr_q <= cfg_data_i[THR_W-1:0];
        REG_CAPACITY:  cap_q <= cfg_data_i[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp capacity into 1..MAX_ENTRIES
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = HELD_W'(1);
    end else if (32'(cap_q) > MAX_ENTRIES) begin
      cap_eff = HELD_W'(MAX_ENTRIES);
    end else begin
      cap_eff = HELD_W'(cap_q);
    end
  end

  // Shared compare unit and per-step terms
  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign search_end = (idx_q >= held_q);
  assign match      = (rd_tag == tag_q);
  assign cnt_inc    = (rd_count == '1) ? rd_count : rd_count + COUNT_WIDTH'(1);
  assign promote    = hit_q && (count_q > COUNT_WIDTH'(thr_q)) && (hit_idx_q != '0);
  assign evict      = !hit_q && (held_q >= cap_eff);
  assign new_held   = evict ? cap_eff : held_q + HELD_W'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && req_i.action == ACT_ACCESS) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (search_end || match) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    idx_d          = idx_q;
    tag_d          = tag_q;
    hit_d          = hit_q;
    hit_idx_d      = hit_idx_q;
    count_d        = count_q;
    ev_tag_d       = ev_tag_q;
    held_d         = held_q;
    total_d        = total_q;
    result_d       = result_q;
    result_valid_d = 1'b0;
    row_ctrl       = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.action == ACT_CLEAR) begin
            // Drop all entries; total holds
            held_d                  = '0;
            result_d                = '0;
            result_d.total_requests = total_q;
            result_valid_d          = 1'b1;
          end else begin
            tag_d    = req_i.page_tag;
            idx_d    = '0;
            hit_d    = 1'b0;
            ev_tag_d = '0;
            total_d  = (total_q == '1) ? total_q : total_q + TOTAL_W'(1);
          end
        end
      end
      ST_SEARCH: begin
        if (!search_end) begin
          // Catch the would-be victim while scanning past it
          if (idx_q == cap_eff - HELD_W'(1)) begin
            ev_tag_d = rd_tag;
          end
          if (match) begin
            hit_d     = 1'b1;
            hit_idx_d = idx_q[IDX_W-1:0];
            count_d   = cnt_inc;
          end else begin
            idx_d = idx_q + HELD_W'(1);
          end
        end
      end
      ST_UPDATE: begin
        if (hit_q) begin
          if (promote) begin
            row_ctrl.shift_en   = 1'b1;
            row_ctrl.shift_top  = hit_idx_q;
            row_ctrl.head_wr    = 1'b1;
            row_ctrl.head_tag   = tag_q;
            row_ctrl.head_count = count_q;
          end else begin
            row_ctrl.upd_en    = 1'b1;
            row_ctrl.upd_idx   = hit_idx_q;
            row_ctrl.upd_count = count_q;
          end
        end else begin
          // Insert at head; anything past the new occupancy falls off
          row_ctrl.shift_en   = 1'b1;
          row_ctrl.shift_top  = IDX_W'(new_held - HELD_W'(1));
          row_ctrl.head_wr    = 1'b1;
          row_ctrl.head_tag   = tag_q;
          row_ctrl.head_count = NEW_COUNT;
          held_d              = new_held;
        end
        result_d.hit            = hit_q;
        result_d.promoted       = promote;
        result_d.evicted        = evict;
        result_d.evicted_tag    = evict ? ev_tag_q : '0;
        result_d.request_count  = hit_q ? count_q : NEW_COUNT;
        result_d.occupancy      = OCC_W'(hit_q ? held_q : new_held);
        result_d.total_requests = total_q;
        result_valid_d          = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      held_q         <= '0;
      total_q        <= '0;
      result_valid_q <= 1'b0;
      idx_q          <= '0;
      hit_q          <= 1'b0;
    end else begin
      state_q        <= state_d;
      held_q         <= held_d;
      total_q        <= total_d;
      result_valid_q <= result_valid_d;
      idx_q          <= idx_d;
      hit_q          <= hit_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tag_q     <= tag_d;
    hit_idx_q <= hit_idx_d;
    count_q   <= count_d;
    ev_tag_q  <= ev_tag_d;
    result_q  <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(held_q) <= MAX_ENTRIES)
    else $error("occupancy above buffer depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |-> idx_q <= held_q)
    else $error("scan index past occupancy");

  a_promote_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.promoted |-> result_o.hit && !result_o.evicted)
    else $error("promotion without hit");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> state_q == ST_IDLE || $past(state_q) == ST_IDLE)
    else $error("result strobe while scanning");
`endif

endmodule

[rtl/tpb_entry_row.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entry row
// Ordered tag/count registers, head at entry 0. Shifts a prefix down by one
// place, writes the head, updates one count, and reads one entry per cycle.
// ----------------------------------------------------------------------------
module tpb_entry_row (
  input  logic                           clk_i,
  input  tpb_pkg::row_ctrl_t             ctrl_i,
  input  logic [tpb_pkg::IDX_W-1:0]      rd_idx_i,
  output logic [tpb_pkg::TAG_WIDTH-1:0]  rd_tag_o,
  output logic [tpb_pkg::COUNT_WIDTH-1:0] rd_count_o
);
  import tpb_pkg::*;

  logic [TAG_WIDTH-1:0]   tags_q   [MAX_ENTRIES];
  logic [COUNT_WIDTH-1:0] counts_q [MAX_ENTRIES];

  assign rd_tag_o   = tags_q[rd_idx_i];
  assign rd_count_o = counts_q[rd_idx_i];

  // Head entry: take the new head or a count update
  always_ff @(posedge clk_i) begin
    if (ctrl_i.head_wr) begin
      tags_q[0]   <= ctrl_i.head_tag;
      counts_q[0] <= ctrl_i.head_count;
    end else if (ctrl_i.upd_en && ctrl_i.upd_idx == '0) begin
      counts_q[0] <= ctrl_i.upd_count;
    end
  end

  // Other entries: advance from the neighbor above when inside the shifted span, else take a count update
  for (genvar i = 1; i < MAX_ENTRIES; i++) begin : g_entry
    always_ff @(posedge clk_i) begin
      if (ctrl_i.shift_en && IDX_W'(i) <= ctrl_i.shift_top) begin
        tags_q[i]   <= tags_q[i-1];
        counts_q[i] <= counts_q[i-1];
      end else if (ctrl_i.upd_en && ctrl_i.upd_idx == IDX_W'(i)) begin
        counts_q[i] <= ctrl_i.upd_count;
      end
    end
  end

endmodule
